[rtl/tlg_pkg.sv]
package tlg_pkg;

	// Grid geometry.
	localparam int GRID_WIDTH  = 32;
	localparam int GRID_HEIGHT = 16;
	localparam int ROW_W       = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

	// Fixed field widths.
	localparam int SEL_W   = 4;
	localparam int CELLS_W = 32;
	localparam int GEN_W   = 14;
	localparam int NBR_W   = 4;

	// Stream data widths, padded to whole bytes.
	localparam int IN_RAW_W  = SEL_W + CELLS_W;
	localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
	localparam int IN_PAD_W  = IN_DATA_W - IN_RAW_W;
	localparam int OUT_RAW_W  = SEL_W + CELLS_W + GEN_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

	// Generation counter wraps to zero after this value.
	localparam logic [GEN_W-1:0] GEN_LIMIT = GEN_W'(9999);

	// Neighbor counts that matter to the rule.
	localparam logic [NBR_W-1:0] NBR_SURVIVE = NBR_W'(2);
	localparam logic [NBR_W-1:0] NBR_BIRTH   = NBR_W'(3);
	localparam logic [NBR_W-1:0] NBR_BIRTH_X = NBR_W'(6);

	// Item kinds carried on tuser.
	localparam logic MODE_STEP = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	// HighLife rule: three neighbors always live, six gives birth to a dead
	// cell, two keeps a live cell.
	function automatic logic next_cell(input logic live, input logic [NBR_W-1:0] n);
		logic res;
		res = (n == NBR_BIRTH) || (!live && (n == NBR_BIRTH_X)) ||
			(live && (n == NBR_SURVIVE));
		return res;
	endfunction

endpackage

[rtl/toroidal_life_generation_step.sv]
// HighLife (B36/S23) generation stepper on a 16 by 32 grid that wraps at
// every edge.
// Input channel s_*: tuser selects the item kind. A load item writes one grid
// row and gives no result. A step item computes the next generation and
// emits all rows on m_*, row 0 first, tlast on the final row, each with the
// generation count after this step (wraps from 9999 to 0).
// The grid is a ring of row cells that rotates by one row per cycle past a
// single row rule unit while the output register can take a row, so a step
// delivers one row per cycle when the receiver never stalls. s_tready stays
// low while a step runs, so no item is taken until every row of the step
// has entered the output register; it is high otherwise, also while the final
// row still waits in the output register.
// When the receiver stalls, the ring and the row counter hold until the
// waiting row is taken; nothing is dropped.
// Reset makes every cell dead, clears the generation count and leaves no
// result pending.
module toroidal_life_generation_step (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// tdata: row_select[3:0], row_cells[35:4], zero fill[39:36]
	input  logic [tlg_pkg::IN_DATA_W-1:0]    s_tdata,
	// tuser: mode (0 step, 1 load)
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// tdata: out_row[3:0], out_cells[35:4], generation[49:36], zero fill[55:50]
	output logic [tlg_pkg::OUT_DATA_W-1:0]   m_tdata,
	// tlast: last_row
	output logic                             m_tlast
);
	import tlg_pkg::*;

	logic                  busy_q;
	logic [ROW_W-1:0]      row_q;
	logic [GEN_W-1:0]      gen_q;
	logic [GRID_WIDTH-1:0] prev_q;
	logic [GRID_WIDTH-1:0] first_q;
	logic                  out_valid_q;
	logic                  out_last_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic                  in_fire;
	logic                  step_start;
	logic                  load_fire;
	logic                  advance;
	logic                  last_row;
	logic [SEL_W-1:0]      row_select;
	logic [CELLS_W-1:0]    row_cells;
	logic [GRID_WIDTH-1:0] down_row;
	logic [GRID_WIDTH-1:0] new_row;
	logic [GRID_WIDTH-1:0] cell_row [GRID_HEIGHT];

	// Input decode.
	assign row_select = s_tdata[SEL_W-1:0];
	assign row_cells  = s_tdata[SEL_W +: CELLS_W];
	assign s_tready   = !busy_q;
	assign in_fire    = s_tvalid && s_tready;
	assign step_start = in_fire && (s_tuser == MODE_STEP);
	assign load_fire  = in_fire && (s_tuser == MODE_LOAD);

	// While a step runs, the ring moves one row whenever the output register can take a row.
	assign advance  = busy_q && (!out_valid_q || m_tready);
	assign last_row = (row_q == ROW_W'(GRID_HEIGHT - 1));

	// Ring of row cells: cell 0 holds the row being computed, the new row
	// enters at the far end.
	for (genvar k = 0; k < GRID_HEIGHT; k++) begin : g_cell
		cell_ctl_t             ctl;
		logic [GRID_WIDTH-1:0] shift_in;

		assign ctl.shift = advance;
		assign ctl.load  = load_fire && ({1'b0, row_select} == (SEL_W + 1)'(k));
		if (k == GRID_HEIGHT - 1) begin : g_tail
			assign shift_in = new_row;
		end else begin : g_body
			assign shift_in = cell_row[k + 1];
		end

		tlg_row_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.shift_in (shift_in),
			.load_in  (row_cells[GRID_WIDTH-1:0]),
			.row      (cell_row[k])
		);
	end

	// The last row wraps around to the saved old row 0.
	assign down_row = last_row ? first_q : cell_row[1];

	tlg_row_rule u_rule (
		.up_row   (prev_q),
		.mid_row  (cell_row[0]),
		.down_row (down_row),
		.next_row (new_row)
	);

	// Step sequencing and generation count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
			gen_q  <= '0;
		end else if (step_start) begin
			busy_q <= 1'b1;
			row_q  <= '0;
			gen_q  <= (gen_q == GEN_LIMIT) ? '0 : gen_q + GEN_W'(1);
		end else if (advance) begin
			row_q <= row_q + ROW_W'(1);
			if (last_row) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The neighbor row above the current one and the old top row.
	always_ff @(posedge clk) begin
		if (step_start) begin
			prev_q  <= cell_row[GRID_HEIGHT-1];
			first_q <= cell_row[0];
		end else if (advance) begin
			prev_q <= cell_row[0];
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_last_q <= last_row;
			out_data_q <= {{OUT_PAD_W{1'b0}}, gen_q, CELLS_W'(new_row), SEL_W'(row_q)};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

[rtl/tlg_row_cell.sv]
module tlg_row_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tlg_pkg::cell_ctl_t           ctl,
	input  logic [tlg_pkg::GRID_WIDTH-1:0] shift_in,
	input  logic [tlg_pkg::GRID_WIDTH-1:0] load_in,
	output logic [tlg_pkg::GRID_WIDTH-1:0] row
);
	import tlg_pkg::*;

	logic [GRID_WIDTH-1:0] row_q;

	// One grid row: takes its neighbor's row when the chain rotates, or a
	// new row from a load item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctl.load) begin
			row_q <= load_in;
		end else if (ctl.shift) begin
			row_q <= shift_in;
		end
	end

	assign row = row_q;

endmodule

[rtl/tlg_row_rule.sv]
module tlg_row_rule (
	input  logic [tlg_pkg::GRID_WIDTH-1:0] up_row,
	input  logic [tlg_pkg::GRID_WIDTH-1:0] mid_row,
	input  logic [tlg_pkg::GRID_WIDTH-1:0] down_row,
	output logic [tlg_pkg::GRID_WIDTH-1:0] next_row
);
	import tlg_pkg::*;

	// Every column counts its eight neighbors, wrapping at the side edges.
	for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
		localparam int CL = (c + GRID_WIDTH - 1) % GRID_WIDTH;
		localparam int CR = (c + 1) % GRID_WIDTH;
		logic [NBR_W-1:0] nbr;

		assign nbr = NBR_W'(up_row[CL]) + NBR_W'(up_row[c]) + NBR_W'(up_row[CR]) +
			NBR_W'(mid_row[CL]) + NBR_W'(mid_row[CR]) +
			NBR_W'(down_row[CL]) + NBR_W'(down_row[c]) + NBR_W'(down_row[CR]);
		assign next_row[c] = next_cell(mid_row[c], nbr);
	end

endmodule

[tb/toroidal_life_generation_step_test.sv]
module toroidal_life_generation_step_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tlg_pkg::*;

	// One emitted grid row as the block should present it.
	typedef struct {
		logic [ROW_W-1:0]   row;
		logic [CELLS_W-1:0] cells;
		logic [GEN_W-1:0]   gen;
		logic               last;
	} grid_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = MODE_STEP;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	// Predicted grid, generation count and the rows still owed by the block.
	logic [CELLS_W-1:0] life_grid [GRID_HEIGHT];
	logic [GEN_W-1:0]   gen_count = '0;
	grid_row_t          owed_rows [$];

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int sink_hold = 0;
	int err_count = 0;

	toroidal_life_generation_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// Watchdog for a hung block.
	initial begin
		#10_000_000;
		$display("toroidal_life_generation_step_test: FAIL");
		$finish;
	end

	// Receiver side: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			m_tready = 1'b0;
			sink_hold = sink_hold - 1;
		end else begin
			m_tready = ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic report_mismatch(input string what, input logic [OUT_DATA_W-1:0] got,
		input logic [OUT_DATA_W-1:0] want);
		err_count++;
		if (err_count <= 40) begin
			$display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
		end
	endtask

	// Next generation of the whole torus; queues the 16 rows it produces.
	function automatic void advance_generation();
		logic [CELLS_W-1:0] next_rows [GRID_HEIGHT];
		int unsigned n;
		logic live;
		logic born;
		grid_row_t item;
		for (int r = 0; r < GRID_HEIGHT; r++) begin
			for (int c = 0; c < GRID_WIDTH; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						if (dr != 0 || dc != 0) begin
							n += life_grid[(r + dr + GRID_HEIGHT) % GRID_HEIGHT]
								[(c + dc + GRID_WIDTH) % GRID_WIDTH];
						end
					end
				end
				live = life_grid[r][c];
				born = (n == NBR_BIRTH) || (!live && n == NBR_BIRTH_X) ||
					(live && n == NBR_SURVIVE);
				next_rows[r][c] = born;
			end
		end
		gen_count = (gen_count == GEN_LIMIT) ? '0 : gen_count + GEN_W'(1);
		for (int r = 0; r < GRID_HEIGHT; r++) begin
			life_grid[r] = next_rows[r];
			item.row = ROW_W'(r);
			item.cells = next_rows[r];
			item.gen = gen_count;
			item.last = (r == GRID_HEIGHT - 1);
			owed_rows.push_back(item);
		end
	endfunction

	// Offers one item at the falling edge and holds it until it is taken.
	task automatic send_item(input logic mode, input logic [SEL_W-1:0] sel,
		input logic [CELLS_W-1:0] cells);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = mode;
		s_tdata = {{IN_PAD_W{1'b0}}, cells, sel};
		do @(posedge clk); while (!s_tready);
		if (mode == MODE_LOAD) begin
			life_grid[sel] = cells;
		end else begin
			advance_generation();
		end
		@(negedge clk);
	endtask

	task automatic load_row(input logic [SEL_W-1:0] sel, input logic [CELLS_W-1:0] cells);
		send_item(MODE_LOAD, sel, cells);
	endtask

	// The row fields of a step item carry junk; the block must ignore them.
	task automatic step_grid();
		send_item(MODE_STEP, SEL_W'($urandom), $urandom);
	endtask

	task automatic stop_sending();
		s_tvalid = 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_for_rows();
		while (owed_rows.size() != 0) @(negedge clk);
	endtask

	// Row contents over a spread of densities, all-dead and all-live included.
	function automatic logic [CELLS_W-1:0] random_row();
		logic [CELLS_W-1:0] v;
		case ($urandom_range(15))
			0: v = '0;
			1: v = '1;
			2, 3, 4, 5: v = $urandom & $urandom & $urandom;
			6, 7, 8, 9: v = $urandom & $urandom;
			10, 11, 12, 13: v = $urandom;
			default: v = $urandom | $urandom;
		endcase
		return v;
	endfunction

	// Checks every row item taken from the block against the oldest one owed.
	always @(posedge clk) begin
		grid_row_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_rows.size() == 0) begin
				report_mismatch("row item with none owed", m_tdata, '0);
			end else begin
				want = owed_rows.pop_front();
				if (m_tdata[3:0] != want.row)
					report_mismatch("out_row", OUT_DATA_W'(m_tdata[3:0]),
						OUT_DATA_W'(want.row));
				if (m_tdata[35:4] != want.cells)
					report_mismatch("out_cells", OUT_DATA_W'(m_tdata[35:4]),
						OUT_DATA_W'(want.cells));
				if (m_tdata[49:36] != want.gen)
					report_mismatch("generation", OUT_DATA_W'(m_tdata[49:36]),
						OUT_DATA_W'(want.gen));
				if (m_tdata[OUT_DATA_W-1:50] != '0)
					report_mismatch("zero fill", OUT_DATA_W'(m_tdata[OUT_DATA_W-1:50]), '0);
				if (m_tlast != want.last)
					report_mismatch("last_row", OUT_DATA_W'(m_tlast),
						OUT_DATA_W'(want.last));
			end
		end
	end

	// A step on the dead grid after reset gives dead rows and generation one.
	task automatic test_empty_step();
		step_grid();
	endtask

	// Birth on six neighbors at a corner, where both edges wrap.
	task automatic test_corner_birth();
		load_row(SEL_W'(15), 32'h8000_0003);
		load_row(SEL_W'(1), 32'h8000_0003);
		step_grid();
	endtask

	// A full live row survives on two neighbors and gives birth on three beside it.
	task automatic test_row_extremes();
		load_row(SEL_W'(0), '1);
		load_row(SEL_W'(15), '0);
		load_row(SEL_W'(1), '0);
		load_row(SEL_W'(2), '0);
		load_row(SEL_W'(14), '0);
		step_grid();
		step_grid();
	endtask

	// Long receiver hold-off while items keep coming, then a pause until drained.
	task automatic test_backpressure();
		sink_hold = 400;
		step_grid();
		for (int i = 0; i < 6; i++) load_row(SEL_W'($urandom), random_row());
		step_grid();
		load_row(SEL_W'($urandom), random_row());
		step_grid();
		stop_sending();
		wait_for_rows();
		step_grid();
	endtask

	// Runs a glider until the generation count wraps past its limit.
	task automatic test_counter_wrap();
		int steps;
		for (int r = 0; r < GRID_HEIGHT; r++) begin
			case (r)
				1: load_row(SEL_W'(r), 32'h0000_0002);
				2: load_row(SEL_W'(r), 32'h0000_0004);
				3: load_row(SEL_W'(r), 32'h0000_0007);
				default: load_row(SEL_W'(r), '0);
			endcase
		end
		steps = (GEN_LIMIT - gen_count) + 2;
		for (int i = 0; i < steps; i++) step_grid();
	endtask

	// Random fresh seeds followed by a few generations, mixed with single rows and single steps.
	task automatic test_random_mix(input int n_items);
		int sent;
		int k;
		sent = 0;
		while (sent < n_items) begin
			k = $urandom_range(99);
			if (k < 20) begin
				for (int r = 0; r < GRID_HEIGHT; r++) load_row(SEL_W'(r), random_row());
				k = $urandom_range(3, 1);
				for (int i = 0; i < k; i++) step_grid();
				sent += GRID_HEIGHT + k;
			end else if (k < 60) begin
				load_row(SEL_W'($urandom), random_row());
				sent++;
			end else begin
				step_grid();
				sent++;
			end
		end
	endtask

	initial begin
		for (int r = 0; r < GRID_HEIGHT; r++) life_grid[r] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		src_idle_pct = 17;
		sink_idle_pct = 76;
		test_empty_step();
		test_corner_birth();
		test_row_extremes();
		test_random_mix(70);

		src_idle_pct = 76;
		sink_idle_pct = 17;
		test_backpressure();
		test_random_mix(70);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_counter_wrap();
		test_random_mix(60);

		stop_sending();
		wait_for_rows();
		repeat (20) @(posedge clk);
		if (err_count == 0 && owed_rows.size() == 0) begin
			$display("toroidal_life_generation_step_test: PASS");
		end else begin
			$display("toroidal_life_generation_step_test: FAIL");
		end
		$finish;
	end

endmodule
